### hw/rtl/deq_pkg.sv
// ---------------------------------------------------------------------------
// deq_pkg
// shared types and defaults of the double-ended queue
// ---------------------------------------------------------------------------
package deq_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int KIND_WIDTH     = 3;
   localparam int STATUS_WIDTH   = 2;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_PUSH_BACK  = 3'd0,
      KIND_PUSH_FRONT = 3'd1,
      KIND_POP_BACK   = 3'd2,
      KIND_POP_FRONT  = 3'd3,
      KIND_CLEAR      = 3'd4
   } kind_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

endpackage

### hw/rtl/deq_if.sv
// ---------------------------------------------------------------------------
// deq_req_if / deq_rsp_if
// valid/ready channels carrying the request and response words
// ---------------------------------------------------------------------------
interface deq_req_if #(
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
);
   logic                            valid;
   logic                            ready;
   logic [deq_pkg::KIND_WIDTH-1:0]  kind;
   logic [DATA_WIDTH-1:0]           push_value;

   modport source (output valid, output kind, output push_value, input ready);
   modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface deq_rsp_if #(
   parameter int DATA_WIDTH  = deq_pkg::DATA_WIDTH_DEF,
   parameter int COUNT_WIDTH = $clog2(deq_pkg::CAPACITY_DEF + 1)
);
   logic                             valid;
   logic                             ready;
   logic [DATA_WIDTH-1:0]            pop_value;
   logic [deq_pkg::STATUS_WIDTH-1:0] status;
   logic [COUNT_WIDTH-1:0]           count;
   logic                             is_empty;
   logic                             is_full;

   modport source (output valid, output pop_value, output status, output count,
                   output is_empty, output is_full, input ready);
   modport sink   (input valid, input pop_value, input status, input count,
                   input is_empty, input is_full, output ready);
endinterface

### hw/rtl/deq_ram.sv
// ---------------------------------------------------------------------------
// deq_ram
// element store: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module deq_ram #(
   parameter  int DEPTH  = deq_pkg::CAPACITY_DEF,
   parameter  int WIDTH  = deq_pkg::DATA_WIDTH_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/double_ended_queue.sv
// ---------------------------------------------------------------------------
// double_ended_queue
// ring-buffer deque with push/pop at both ends and clear
// the request word passes the store read stage, then the response register,
//   on its way to the response word; throughput: one word per cycle while
//   the response channel is ready, with store access in the accept cycle
// reset: synchronous, clears pointers, count and valid flags; store is
//   not cleared
// ---------------------------------------------------------------------------
module double_ended_queue #(
   parameter int CAPACITY   = deq_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   deq_req_if.sink   req_chan,
   deq_rsp_if.source rsp_chan
);

   localparam int PTR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(CAPACITY);

   logic [PTR_W-1:0] front_ff, front_in;
   logic [PTR_W-1:0] back_ff, back_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [PTR_W-1:0] front_next, front_prev, back_next, back_prev;
   logic             full, empty;
   logic             wr_en;
   logic [PTR_W-1:0] wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;
   logic             pop_ok;
   deq_pkg::status_type status;

   logic             accept, s1_move;

   logic             s1_valid_ff;
   logic             s1_pop_ff;
   deq_pkg::status_type s1_status_ff;
   logic [CNT_W-1:0] s1_count_ff;

   logic                  out_valid_ff;
   logic [DATA_WIDTH-1:0] out_pop_value_ff;
   deq_pkg::status_type   out_status_ff;
   logic [CNT_W-1:0]      out_count_ff;
   logic                  out_is_empty_ff;
   logic                  out_is_full_ff;

   assign s1_move        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_move;
   assign accept         = req_chan.valid && req_chan.ready;

   assign full  = count_ff == CNT_MAX;
   assign empty = count_ff == '0;

   // ring wrap at both ends
   assign front_next = (front_ff == PTR_LAST) ? '0 : front_ff + PTR_W'(1);
   assign front_prev = (front_ff == '0) ? PTR_LAST : front_ff - PTR_W'(1);
   assign back_next  = (back_ff == PTR_LAST) ? '0 : back_ff + PTR_W'(1);
   assign back_prev  = (back_ff == '0) ? PTR_LAST : back_ff - PTR_W'(1);

   always_comb begin
      front_in = front_ff;
      back_in  = back_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = back_ff;
      rd_addr  = front_ff;
      pop_ok   = 1'b0;
      status   = deq_pkg::STATUS_DONE;
      case (req_chan.kind)
         deq_pkg::KIND_PUSH_BACK: begin
            if (full) begin
               status = deq_pkg::STATUS_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = back_ff;
               back_in  = back_next;
               count_in = count_ff + CNT_W'(1);
            end
         end
         deq_pkg::KIND_PUSH_FRONT: begin
            if (full) begin
               status = deq_pkg::STATUS_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = front_prev;
               front_in = front_prev;
               count_in = count_ff + CNT_W'(1);
            end
         end
         deq_pkg::KIND_POP_BACK: begin
            if (empty) begin
               status = deq_pkg::STATUS_EMPTY;
            end else begin
               pop_ok   = 1'b1;
               rd_addr  = back_prev;
               back_in  = back_prev;
               count_in = count_ff - CNT_W'(1);
            end
         end
         deq_pkg::KIND_POP_FRONT: begin
            if (empty) begin
               status = deq_pkg::STATUS_EMPTY;
            end else begin
               pop_ok   = 1'b1;
               rd_addr  = front_ff;
               front_in = front_next;
               count_in = count_ff - CNT_W'(1);
            end
         end
         deq_pkg::KIND_CLEAR: begin
            front_in = '0;
            back_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   deq_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (accept && wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_chan.push_value),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

   // store read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pop_ff    <= pop_ok;
         s1_status_ff <= status;
         s1_count_ff  <= count_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_pop_value_ff <= s1_pop_ff ? rd_data : '0;
         out_status_ff    <= s1_status_ff;
         out_count_ff     <= s1_count_ff;
         out_is_empty_ff  <= s1_count_ff == '0;
         out_is_full_ff   <= s1_count_ff == CNT_MAX;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.pop_value = out_pop_value_ff;
   assign rsp_chan.status    = out_status_ff;
   assign rsp_chan.count     = out_count_ff;
   assign rsp_chan.is_empty  = out_is_empty_ff;
   assign rsp_chan.is_full   = out_is_full_ff;

endmodule
